/* rtl/core/evfdo_pkg.sv */
// ----------------------------------------------------------------------------
// evfdo_pkg
// Shared types and codes for the drop-oldest event queue.
// ----------------------------------------------------------------------------
package evfdo_pkg;

   localparam int CODE_W  = 16;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_LOST    = 2'd2,
      STATUS_DROPPED = 2'd3
   } status_type;

   typedef enum logic {
      REG_TRIGGER_CODE = 1'b0,
      REG_CLEAR_CODE   = 1'b1
   } reg_index_type;

endpackage

/* rtl/core/event_fifo_drop_oldest.sv */
// ----------------------------------------------------------------------------
// event_fifo_drop_oldest
// Bounded event queue that discards its oldest entry when a push finds it full.
//
// A command is taken on each rising edge with start high and busy low; busy is
// always low, so one push or pop enters every cycle. req_func selects push or
// pop and req_event_code carries the code to store.
// Every command yields exactly one result beat, shown for one cycle with
// rsp_valid high in the cycle after the command was taken. The receiver
// cannot stall, so the beat is accepted at the end of that cycle.
// Throughput is one command per cycle; each pop makes a single registered
// read of the event memory.
// A push to a full queue drops the oldest entry, reports status 3 and sets a
// sticky lost flag; the next pop that finds events reports status 2, clears
// the flag and removes nothing. Pushing the trigger or clear code configured
// over the APB port sets a sticky status bit.
// Synchronous reset empties the queue, clears all flags and both code
// registers. The event memory itself is not cleared; only written entries are
// ever read.
// ----------------------------------------------------------------------------
module event_fifo_drop_oldest #(
   parameter int QUEUE_DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_func,
   input  logic [evfdo_pkg::CODE_W-1:0]           req_event_code,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic [evfdo_pkg::CODE_W-1:0]           rsp_popped_code,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       rsp_queued_count,
   output logic                                   rsp_trigger_status,
   output logic                                   rsp_clear_status,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [evfdo_pkg::CSR_AW-1:0]           paddr,
   input  logic [evfdo_pkg::CSR_DW-1:0]           pwdata,
   output logic [evfdo_pkg::CSR_DW-1:0]           prdata,
   output logic                                   pready
);
   import evfdo_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [CODE_W-1:0] event_mem [QUEUE_DEPTH];

   logic [CODE_W-1:0] trigger_code_ff, trigger_code_in;
   logic [CODE_W-1:0] clear_code_ff, clear_code_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              lost_ff, lost_in;
   logic              trigger_seen_ff, trigger_seen_in;
   logic              clear_seen_ff, clear_seen_in;
   logic              valid_ff;
   status_type        status_ff, status_in;
   logic              pop_ok_ff, pop_ok_in;
   logic [CODE_W-1:0] rd_data_ff;

   logic              accept;
   logic              push_acc;
   logic              csr_write;
   reg_index_type     csr_index;
   logic [PTR_W-1:0]  rd_ptr_next;
   logic [PTR_W-1:0]  wr_ptr_next;

   assign busy      = 1'b0;
   assign pready    = 1'b1;
   assign accept    = start && !busy;
   assign push_acc  = accept && (req_func == FUNC_PUSH);
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[2]);

   assign rd_ptr_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign wr_ptr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);

   always_comb begin
      trigger_code_in = trigger_code_ff;
      clear_code_in   = clear_code_ff;
      if (csr_write) begin
         case (csr_index)
            REG_TRIGGER_CODE: trigger_code_in = pwdata[CODE_W-1:0];
            REG_CLEAR_CODE:   clear_code_in   = pwdata[CODE_W-1:0];
            default:          trigger_code_in = trigger_code_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TRIGGER_CODE: prdata = CSR_DW'(trigger_code_ff);
         REG_CLEAR_CODE:   prdata = CSR_DW'(clear_code_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      rd_ptr_in       = rd_ptr_ff;
      wr_ptr_in       = wr_ptr_ff;
      count_in        = count_ff;
      lost_in         = lost_ff;
      trigger_seen_in = trigger_seen_ff;
      clear_seen_in   = clear_seen_ff;
      status_in       = STATUS_DONE;
      pop_ok_in       = 1'b0;
      if (accept) begin
         if (req_func == FUNC_PUSH) begin
            wr_ptr_in = wr_ptr_next;
            if (count_ff == CNT_FULL) begin
               rd_ptr_in = rd_ptr_next;
               lost_in   = 1'b1;
               status_in = STATUS_DROPPED;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
            if (req_event_code == trigger_code_ff) begin
               trigger_seen_in = 1'b1;
            end
            if (req_event_code == clear_code_ff) begin
               clear_seen_in = 1'b1;
            end
         end else if (count_ff == '0) begin
            status_in = STATUS_EMPTY;
         end else if (lost_ff) begin
            lost_in   = 1'b0;
            status_in = STATUS_LOST;
         end else begin
            rd_ptr_in = rd_ptr_next;
            count_in  = count_ff - CNT_W'(1);
            pop_ok_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_code_ff <= '0;
         clear_code_ff   <= '0;
         rd_ptr_ff       <= '0;
         wr_ptr_ff       <= '0;
         count_ff        <= '0;
         lost_ff         <= 1'b0;
         trigger_seen_ff <= 1'b0;
         clear_seen_ff   <= 1'b0;
         valid_ff        <= 1'b0;
         pop_ok_ff       <= 1'b0;
      end else begin
         trigger_code_ff <= trigger_code_in;
         clear_code_ff   <= clear_code_in;
         rd_ptr_ff       <= rd_ptr_in;
         wr_ptr_ff       <= wr_ptr_in;
         count_ff        <= count_in;
         lost_ff         <= lost_in;
         trigger_seen_ff <= trigger_seen_in;
         clear_seen_ff   <= clear_seen_in;
         valid_ff        <= accept;
         pop_ok_ff       <= pop_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (push_acc) begin
         event_mem[wr_ptr_ff] <= req_event_code;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ok_in) begin
         rd_data_ff <= event_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_popped_code    = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_queued_count   = count_ff;
   assign rsp_trigger_status = trigger_seen_ff;
   assign rsp_clear_status   = clear_seen_ff;

endmodule
